// ----- hdl/bilinear_upscale_2x_defines.svh -----
// Assertion macros shared by the bilinear 2x upscaler RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef BILINEAR_UPSCALE_2X_DEFINES_SVH
`define BILINEAR_UPSCALE_2X_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define BU2X_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define BU2X_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bu2x_pkg.sv -----
// Package of the bilinear 2x upscaler: widths, register indexes, job struct
// and the channel-wise pixel mean. No dependencies.
package bu2x_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 24;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int OROW_W     = 13;
  localparam int OCOL_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int N_SLOT     = 12;
  localparam int SLOT_W     = $clog2(N_SLOT);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Row selects inside one item's result slots.
  typedef enum logic [1:0] {
    ROW_ABOVE = 2'd0,
    ROW_EVEN  = 2'd1,
    ROW_BELOW = 2'd2
  } row_sel_t;

  // Everything the output sequencer needs for one input item.
  typedef struct packed {
    logic [N_SLOT-1:0] mask;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              frame_end;
    pix_t              above_p0;
    pix_t              above_p1;
    pix_t              above_q;
    pix_t              even_p0;
    pix_t              even_p1;
    pix_t              even_q;
  } job_t;

  // Truncated mean of two pixels, channel by channel.
  function automatic pix_t mean_px(pix_t a, pix_t b);
    logic [8:0] s;
    pix_t       m;
    m = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = {1'b0, a[8*ch +: 8]} + {1'b0, b[8*ch +: 8]};
      m[8*ch +: 8] = s[8:1];
    end
    return m;
  endfunction

endpackage

// ----- hdl/bu2x_if.sv -----
// Valid/ready channel interfaces of the bilinear 2x upscaler.
// Depends on bu2x_pkg for the field widths.
interface bu2x_in_if;
  logic                         valid;
  logic                         ready;
  logic [bu2x_pkg::PIX_W-1:0]   pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bu2x_out_if;
  logic                         valid;
  logic                         ready;
  logic [bu2x_pkg::OROW_W-1:0]  out_row;
  logic [bu2x_pkg::OCOL_W-1:0]  out_col;
  logic [bu2x_pkg::PIX_W-1:0]   pixel_out;
  logic                         run_last;
  logic                         frame_done;

  modport source (output valid, output out_row, output out_col, output pixel_out,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input pixel_out,
                  input run_last, input frame_done, output ready);
endinterface

// ----- hdl/bu2x_ram.sv -----
// Generic simple dual-port RAM with registered, enabled read.
// Read-first: a read and a write of one address in one cycle return the old data.
module bu2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one read port; the read register holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/bu2x_emit.sv -----
// Output sequencer of the bilinear 2x upscaler: holds one item's job and hands out
// its results one per cycle while out_pix is ready. Depends on bu2x_pkg and bu2x_out_if.
`include "bilinear_upscale_2x_defines.svh"

module bu2x_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  bu2x_pkg::job_t    job,
  output logic              can_load,
  bu2x_out_if.source        out_pix
);
  import bu2x_pkg::*;

  logic [N_SLOT-1:0] mask_r, mask_nxt;
  job_t              job_r;
  logic [N_SLOT-1:0] first_bit;
  logic [N_SLOT-1:0] rest;
  logic [SLOT_W-1:0] slot;
  logic              out_fire;
  row_sel_t          row_sel;
  logic [1:0]        col_sel;
  logic [OROW_W-1:0] row_base;
  logic [OCOL_W-1:0] col_base;

  // Lowest pending slot goes out first; the rest wait.
  always_comb begin
    first_bit = mask_r & (~mask_r + N_SLOT'(1));
    rest      = mask_r & ~first_bit;
    slot      = '0;
    for (int i = 0; i < N_SLOT; i++) begin
      slot = slot | (first_bit[i] ? SLOT_W'(i) : SLOT_W'(0));
    end
  end

  assign out_fire = out_pix.valid && out_pix.ready;
  assign can_load = (mask_r == '0) || (out_fire && (rest == '0));

  // Slot bookkeeping.
  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = job.mask;
    end else if (out_fire) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // Job payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

  // Decode the slot into output row, column and pixel.
  assign row_sel  = row_sel_t'(slot[3:2]);
  assign col_sel  = slot[1:0];
  assign row_base = {job_r.row, 1'b0};
  assign col_base = {job_r.col, 1'b0};

  always_comb begin
    unique case (row_sel)
      ROW_ABOVE: out_pix.out_row = row_base - OROW_W'(1);
      ROW_EVEN:  out_pix.out_row = row_base;
      ROW_BELOW: out_pix.out_row = row_base + OROW_W'(1);
      default:   out_pix.out_row = row_base;
    endcase
    unique case (col_sel)
      2'd0:    out_pix.out_col = col_base - OCOL_W'(2);
      2'd1:    out_pix.out_col = col_base - OCOL_W'(1);
      2'd2:    out_pix.out_col = col_base;
      default: out_pix.out_col = col_base + OCOL_W'(1);
    endcase
    if (row_sel == ROW_ABOVE) begin
      unique case (col_sel)
        2'd0:    out_pix.pixel_out = job_r.above_p0;
        2'd1:    out_pix.pixel_out = job_r.above_p1;
        default: out_pix.pixel_out = job_r.above_q;
      endcase
    end else begin
      unique case (col_sel)
        2'd0:    out_pix.pixel_out = job_r.even_p0;
        2'd1:    out_pix.pixel_out = job_r.even_p1;
        default: out_pix.pixel_out = job_r.even_q;
      endcase
    end
  end

  assign out_pix.valid      = (mask_r != '0);
  assign out_pix.run_last   = (rest == '0);
  assign out_pix.frame_done = (rest == '0) && job_r.frame_end;

  // Checks on the sequencer.
  `BU2X_ASSERT_IMPL(a_frame_on_run_end, out_pix.valid && out_pix.frame_done, out_pix.run_last, "frame_done without run_last")
  `BU2X_ASSERT_NEXT(a_run_continues, out_fire && !out_pix.run_last, out_pix.valid, "item results cut short")
  `BU2X_ASSERT_IMPL(a_load_when_free, load, can_load, "job loaded over pending results")

endmodule

// ----- hdl/bilinear_upscale_2x.sv -----
// Top level of the streaming bilinear 2x upscaler: counters, line store,
// interpolation and output sequencer. Depends on bu2x_pkg, bu2x_if, bu2x_ram, bu2x_emit.
//
//   channel   direction  handshake            payload
//   in_pix    sink       valid/ready          pixel_in
//   out_pix   source     valid/ready          out_row, out_col, pixel_out, run_last, frame_done
//   cfg_*     sink       cfg_we (no wait)     cfg_idx, cfg_wdata
//
// An item is accepted whenever the stage ahead of the sequencer is empty or moves on in
// that cycle; the line store is read and written at acceptance, its data is used in the
// following cycle in the interpolation stage, and the first result is offered once the
// item is loaded into the sequencer's registers. An item yields as many results as it
// has set slots (4 for an ordinary pixel, none at a first column, up to 12 at the last
// row and column), handed out in turn by the single output port. Reset clears counters
// and edge pixels; the line store gets no clearing pass. Output stalls back up into the
// input through a one-item stage.
`include "bilinear_upscale_2x_defines.svh"

module bilinear_upscale_2x (
  input  logic                             clk,
  input  logic                             rst_n,
  bu2x_in_if.sink                          in_pix,
  bu2x_out_if.source                       out_pix,
  input  logic                             cfg_we,
  input  logic [bu2x_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bu2x_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bu2x_pkg::*;

  logic [WREG_W-1:0] width_r, width_nxt;
  logic [HREG_W-1:0] height_r, height_nxt;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  pix_t              left_r, ul_r;
  logic              last_col, last_row;
  logic              in_fire;

  logic              s1_valid_r, s1_valid_nxt;
  pix_t              s1_cur_r, s1_left_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              s1_last_col_r, s1_last_row_r;
  logic              s1_move;

  pix_t              up;
  pix_t              e1, u1;
  logic [3:0]        col_en;
  job_t              job;
  logic              can_load;

  // Configuration registers.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[WREG_W-1:0];
        CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WREG_W'(1);
      height_r <= HREG_W'(1);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // Geometry limited to the supported range.
  always_comb begin
    if (width_r == '0) begin
      w_eff = WREG_W'(1);
    end else if (width_r > WREG_W'(MAX_WIDTH)) begin
      w_eff = WREG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HREG_W'(1);
    end else if (height_r > HREG_W'(MAX_HEIGHT)) begin
      h_eff = HREG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  assign last_col = (WREG_W'(col_r) + WREG_W'(1)) >= w_eff;
  assign last_row = (HREG_W'(row_r) + HREG_W'(1)) >= h_eff;

  // Intake: the stage ahead of the sequencer frees up as its item moves on.
  assign s1_move      = s1_valid_r && can_load;
  assign in_pix.ready = !s1_valid_r || can_load;
  assign in_fire      = in_pix.valid && in_pix.ready;

  // Position counters.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      left_r     <= '0;
      ul_r       <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        left_r <= in_pix.pixel_in;
      end
      // The line store entry of this column is the upper-left one for the next.
      if (s1_move) begin
        ul_r <= up;
      end
    end
  end

  // Item payload held for the interpolation stage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cur_r      <= in_pix.pixel_in;
      s1_left_r     <= left_r;
      s1_col_r      <= col_r;
      s1_row_r      <= row_r;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
    end
  end

  // Line store of the previous input row: read old, write new at one address.
  bu2x_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_r),
    .wdata (in_pix.pixel_in),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (up)
  );

  // Interpolation of the three output rows touched by this item.
  assign e1 = mean_px(s1_left_r, s1_cur_r);
  assign u1 = mean_px(ul_r, up);
  assign col_en = {s1_last_col_r, s1_last_col_r, (s1_col_r != '0), (s1_col_r != '0)};

  always_comb begin
    job.mask      = {(s1_last_row_r ? col_en : 4'b0000), col_en,
                     ((s1_row_r != '0) ? col_en : 4'b0000)};
    job.row       = s1_row_r;
    job.col       = s1_col_r;
    job.frame_end = s1_last_col_r && s1_last_row_r;
    job.above_p0  = mean_px(ul_r, s1_left_r);
    job.above_p1  = mean_px(u1, e1);
    job.above_q   = mean_px(up, s1_cur_r);
    job.even_p0   = s1_left_r;
    job.even_p1   = e1;
    job.even_q    = s1_cur_r;
  end

  bu2x_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_move),
    .job      (job),
    .can_load (can_load),
    .out_pix  (out_pix)
  );

  // Checks on intake and counters.
  `BU2X_ASSERT_NEXT(a_stage_filled, in_fire, s1_valid_r, "accepted item not held")
  `BU2X_ASSERT_NEXT(a_col_wraps, in_fire && last_col, col_r == '0, "column count did not wrap")
  `BU2X_ASSERT_IMPL(a_no_overrun, in_fire && s1_valid_r, s1_move, "stage overwritten")

endmodule
